### sv/tfm_pkg.sv
// Shared types and constants for the thruster fuel meter and PWM block.
package tfm_pkg;

    localparam int unsigned FULL_FUEL_RESET = 32'd210240000;
    localparam int unsigned MS_PER_SEC      = 1000;
    localparam int unsigned THRUSTERS       = 4;
    localparam int unsigned SPENT_W         = 38;
    localparam int unsigned DIV_STEPS       = SPENT_W;
    localparam int unsigned CNT_W           = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADJ,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic adj;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

### sv/tfm_ctrl.sv
// Controller state machine that sequences one update through the datapath.
module tfm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tfm_pkg::t_dp_status i_status,
    output tfm_pkg::t_dp_cmd    o_cmd
);

    tfm_pkg::t_state r_state;
    tfm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tfm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tfm_pkg::ST_MUL;
                end
            end
            tfm_pkg::ST_MUL: n_state = tfm_pkg::ST_ADJ;
            tfm_pkg::ST_ADJ: n_state = tfm_pkg::ST_DIV;
            tfm_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = tfm_pkg::ST_FIN;
                end
            end
            tfm_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = tfm_pkg::ST_IDLE;
                end
            end
            default: n_state = tfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tfm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tfm_pkg::ST_MUL: o_cmd.mul      = 1'b1;
            tfm_pkg::ST_ADJ: o_cmd.adj      = 1'b1;
            tfm_pkg::ST_DIV: o_cmd.div_step = 1'b1;
            tfm_pkg::ST_FIN: o_cmd.finish   = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### sv/tfm_dp.sv
// Datapath: consumption product, residual drain, bit-serial divider and result register.
module tfm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfm_pkg::t_dp_cmd    i_cmd,
    output tfm_pkg::t_dp_status o_status,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_data,
    input  logic [63:0]         i_in_data,
    input  logic                i_in_user,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [47:0]         o_out_data,
    output logic                o_out_user
);

    localparam int unsigned SW = tfm_pkg::SPENT_W;

    // Control and architectural state.
    logic [31:0] r_full_fuel;
    logic [31:0] r_residual;
    logic [15:0] r_held;
    logic        r_out_valid;

    // Captured update.
    logic [31:0] r_elapsed;
    logic        r_new_valid;
    logic [3:0]  r_new_dirs;
    logic [3:0]  r_new_mag;
    logic [7:0]  r_new_dur;
    logic [15:0] r_fuel_in;

    // Working registers.
    logic [SW-1:0]                r_spent;
    logic                         r_expire;
    logic                         r_used_one;
    logic [SW-1:0]                r_quo;
    logic [31:0]                  r_rem;
    logic [tfm_pkg::CNT_W-1:0]    r_div_cnt;

    // Result register.
    logic [47:0] r_out_data;
    logic        r_out_user;

    logic [2:0]  w_active;
    logic [5:0]  w_rate;
    logic [17:0] w_hold_ms;
    logic [31:0] w_unit;
    logic [32:0] w_rem_sh;
    logic        w_q_bit;
    logic [31:0] w_rem_sub;
    logic [SW:0] w_used;
    logic [15:0] w_fuel_out;
    logic [15:0] w_held_next;
    logic [7:0]  w_pwm;

    assign w_active  = 3'($countones(r_held[3:0]));
    assign w_rate    = 6'(w_active) * 6'(r_held[7:4]);
    assign w_hold_ms = 18'(tfm_pkg::MS_PER_SEC) * 18'(r_held[15:8]);
    // A zero register value divides as one.
    assign w_unit    = (r_full_fuel == 32'd0) ? 32'd1 : r_full_fuel;

    // One restoring divide step: shift in the next dividend bit and try the subtract.
    assign w_rem_sh  = {r_rem, r_quo[SW-1]};
    assign w_rem_sub = 32'(w_rem_sh - {1'b0, w_unit});
    assign w_q_bit   = (w_rem_sh >= {1'b0, w_unit});

    assign w_used     = {1'b0, r_quo} + (SW+1)'(r_used_one);
    assign w_fuel_out = (w_used >= (SW+1)'(r_fuel_in)) ? 16'd0
                                                        : r_fuel_in - w_used[15:0];

    always_comb begin
        w_held_next = r_held;
        if (r_new_valid) begin
            w_held_next = {r_new_dur, r_new_mag, r_new_dirs};
        end else if (r_expire) begin
            w_held_next = '0;
        end
    end

    assign w_pwm = {w_held_next[7:4], 4'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_fuel <= tfm_pkg::FULL_FUEL_RESET;
            r_residual  <= tfm_pkg::FULL_FUEL_RESET;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_full_fuel <= i_cfg_data;
            end
            if (i_cmd.adj && (r_spent >= SW'(r_residual))) begin
                r_residual <= r_full_fuel;
            end else if (i_cmd.finish) begin
                r_residual <= r_residual - r_rem;
            end
            if (i_cmd.finish) begin
                r_held      <= w_held_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_elapsed   <= i_in_data[31:0];
            r_new_dirs  <= i_in_data[35:32];
            r_new_mag   <= i_in_data[39:36];
            r_new_dur   <= i_in_data[47:40];
            r_fuel_in   <= i_in_data[63:48];
            r_new_valid <= i_in_user;
        end
        if (i_cmd.mul) begin
            r_spent  <= SW'(r_elapsed) * SW'(w_rate);
            r_expire <= (r_elapsed >= 32'(w_hold_ms));
        end
        if (i_cmd.adj) begin
            r_rem     <= '0;
            r_div_cnt <= tfm_pkg::CNT_W'(tfm_pkg::DIV_STEPS - 1);
            if (r_spent >= SW'(r_residual)) begin
                r_quo      <= r_spent - SW'(r_residual);
                r_used_one <= 1'b1;
            end else begin
                r_quo      <= r_spent;
                r_used_one <= 1'b0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_q_bit ? w_rem_sub : w_rem_sh[31:0];
            r_quo     <= {r_quo[SW-2:0], w_q_bit};
            r_div_cnt <= r_div_cnt - tfm_pkg::CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_out_data <= {w_held_next[3] ? w_pwm : 8'd0,
                           w_held_next[2] ? w_pwm : 8'd0,
                           w_held_next[1] ? w_pwm : 8'd0,
                           w_held_next[0] ? w_pwm : 8'd0,
                           w_fuel_out};
            r_out_user <= r_new_valid;
        end
    end

    assign o_status.div_last = (r_div_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_out_user        = r_out_user;

endmodule

### sv/thruster_fuel_meter_pwm.sv
// The block works on one update at a time; the bit-serial divider by full_fuel retires
// one quotient bit a cycle. A new input is taken while the previous result still waits
// in the output register. Reset (i_rst_n low, synchronous) clears the held command,
// reloads the residual and full_fuel to 210240000 and empties the output register.
module thruster_fuel_meter_pwm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: full_fuel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Update input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] elapsed_ms, [35:32] new_dirs, [39:36] new_mag, [47:40] new_dur,
    // [63:48] fuel_in.
    input  logic [63:0] s_axis_tdata,
    // [0] new_valid.
    input  logic        s_axis_tuser,
    // Result output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] fuel_out, [23:16] pwm_left, [31:24] pwm_right, [39:32] pwm_up,
    // [47:40] pwm_down.
    output logic [47:0] m_axis_tdata,
    // [0] cmd_taken.
    output logic        m_axis_tuser
);

    tfm_pkg::t_dp_cmd    w_cmd;
    tfm_pkg::t_dp_status w_status;

    // Always ready; the user changes the register only while idle, unchecked.
    assign o_cfg_ready = 1'b1;

    // The controller walks each update through multiply, residual drain, the
    // divide loop and the final fuel and command update.
    tfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the state, the divider and the output register.
    tfm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // Once a transaction is accepted, no other is taken until it is processed.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A result is written only into a free output register.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_status.out_free)
        else $error("result overwrote a pending output");

    // Every finished update presents a result in the next cycle.
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> m_axis_tvalid)
        else $error("finished update produced no output");
`endif

endmodule

### tb/sv/thruster_fuel_meter_pwm_test.sv
// Self-checking testbench for the thruster fuel meter and PWM block.
module thruster_fuel_meter_pwm_test;

    timeunit 1ns;
    timeprecision 1ps;

    // One update transaction as offered on the slave side.
    typedef struct {
        logic [31:0] elapsed;
        logic        valid;
        logic [3:0]  dirs;
        logic [3:0]  mag;
        logic [7:0]  dur;
        logic [15:0] fuel;
    } t_update;

    // One result transaction as expected on the master side.
    typedef struct {
        logic [15:0] fuel_out;
        logic        taken;
        logic [7:0]  pwm [tfm_pkg::THRUSTERS];
    } t_meter_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // elapsed_ms, new_dirs, new_mag, new_dur, fuel_in
    logic        s_axis_tuser = 1'b0; // new_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // fuel_out, pwm_left, pwm_right, pwm_up, pwm_down
    logic        m_axis_tuser;        // cmd_taken

    thruster_fuel_meter_pwm uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Updates waiting to be offered, and results the meter model says must come back.
    t_update       update_q [$];
    t_meter_result pending_results [$];

    // Private copy of the block state, kept in step with accepted transactions.
    logic [31:0] full_fuel_reg = tfm_pkg::FULL_FUEL_RESET;
    logic [15:0] held_cmd = '0;
    logic [31:0] residual = tfm_pkg::FULL_FUEL_RESET;

    int mismatches = 0;

    // Handshake flags passed from the rising-edge monitor to the falling-edge drivers.
    bit upd_accepted = 0;
    bit res_accepted = 0;
    bit hold_req = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    bit src_burst = 0;
    bit sink_burst = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Fuel accounting for one update: the held command burns partial units over the
    // elapsed time, whole units come off the fuel level, then the command is updated.
    function automatic t_meter_result meter_update(t_update u);
        t_meter_result r;
        longint unsigned spent, used, unit, hold_ms;
        int unsigned active;
        active = $countones(held_cmd[3:0]);
        spent = 64'(u.elapsed) * 64'(active) * 64'(held_cmd[7:4]);
        unit = (full_fuel_reg == 0) ? 64'd1 : 64'(full_fuel_reg);
        used = 0;
        // Crossing the residual counts one whole unit and restarts it from full_fuel.
        if (spent >= 64'(residual)) begin
            spent = spent - 64'(residual);
            used = 1;
            residual = full_fuel_reg;
        end
        used = used + spent / unit;
        residual = residual - 32'(spent % unit);
        r.fuel_out = (used >= 64'(u.fuel)) ? 16'd0 : u.fuel - 16'(used);
        hold_ms = 64'(tfm_pkg::MS_PER_SEC) * 64'(held_cmd[15:8]);
        if (u.valid)
            held_cmd = {u.dur, u.mag, u.dirs};
        else if (64'(u.elapsed) >= hold_ms)
            held_cmd = '0;
        r.taken = u.valid;
        for (int i = 0; i < tfm_pkg::THRUSTERS; i++)
            r.pwm[i] = held_cmd[i] ? {held_cmd[7:4], 4'b0000} : 8'd0;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // Rising edge: every accepted update is run through the model, every accepted
    // result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_update       u;
        t_meter_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                u.elapsed = s_axis_tdata[31:0];
                u.dirs    = s_axis_tdata[35:32];
                u.mag     = s_axis_tdata[39:36];
                u.dur     = s_axis_tdata[47:40];
                u.fuel    = s_axis_tdata[63:48];
                u.valid   = s_axis_tuser;
                pending_results.push_back(meter_update(u));
                upd_accepted = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                res_accepted = 1;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result transaction with none expected, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_results.pop_front();
                    check_field("fuel_out", want.fuel_out, m_axis_tdata[15:0]);
                    check_field("cmd_taken", 16'(want.taken), 16'(m_axis_tuser));
                    check_field("pwm_left", 16'(want.pwm[0]), 16'(m_axis_tdata[23:16]));
                    check_field("pwm_right", 16'(want.pwm[1]), 16'(m_axis_tdata[31:24]));
                    check_field("pwm_up", 16'(want.pwm[2]), 16'(m_axis_tdata[39:32]));
                    check_field("pwm_down", 16'(want.pwm[3]), 16'(m_axis_tdata[47:40]));
                end
            end
        end
    end

    // Falling edge, slave side: after each transaction the source waits a randomly drawn src_gap
    // before the next one, except in bursts where it keeps tvalid high back to back.
    always @(negedge i_clk) begin
        logic    nxt_valid;
        t_update u;
        nxt_valid = s_axis_tvalid;
        if (upd_accepted) begin
            upd_accepted = 0;
            nxt_valid = 1'b0;
            if ($urandom_range(0, 39) == 0)
                src_burst = !src_burst;
            src_gap = src_burst ? 0 : $urandom_range(0, 7);
        end
        if (!nxt_valid && i_rst_n) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (update_q.size() != 0) begin
                u = update_q.pop_front();
                s_axis_tdata <= {u.fuel, u.dur, u.mag, u.dirs, u.elapsed};
                s_axis_tuser <= u.valid;
                nxt_valid = 1'b1;
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // Falling edge, master side: random back-pressure per result, plus the long
    // hold-off that lets the block fill up and stall its input.
    always @(negedge i_clk) begin
        if (res_accepted) begin
            res_accepted = 0;
            if ($urandom_range(0, 39) == 0)
                sink_burst = !sink_burst;
            sink_gap = sink_burst ? 0 : $urandom_range(0, 7);
        end
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        m_axis_tready <= (hold_left == 0) && (sink_gap == 0);
        if (hold_left > 0)
            hold_left--;
        else if (sink_gap > 0)
            sink_gap--;
    end

    task automatic push_update(input logic [31:0] elapsed, input logic valid,
                               input logic [3:0] dirs, input logic [3:0] mag,
                               input logic [7:0] dur, input logic [15:0] fuel);
        t_update u;
        u.elapsed = elapsed;
        u.valid = valid;
        u.dirs = dirs;
        u.mag = mag;
        u.dur = dur;
        u.fuel = fuel;
        update_q.push_back(u);
    endtask

    // Mostly command/update sequences where the held command survives a few
    // updates and burns fuel, mixed with long gaps that clear it and huge ones
    // that saturate the fuel level.
    function automatic t_update rand_update();
        t_update     u;
        int unsigned pick;
        u.valid = ($urandom_range(0, 99) < 35);
        u.dirs = 4'($urandom);
        u.mag = 4'($urandom);
        u.dur = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            u.elapsed = $urandom_range(0, 1500);
        else if (pick < 70)
            u.elapsed = $urandom_range(0, 300000);
        else if (pick < 85)
            u.elapsed = $urandom;
        else if (pick < 95)
            u.elapsed = $urandom_range(0, 10);
        else
            u.elapsed = pick[0] ? 32'hFFFF_FFFF : 32'd0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            u.fuel = 16'($urandom);
        else if (pick < 70)
            u.fuel = 16'($urandom_range(0, 40));
        else if (pick < 80)
            u.fuel = 16'd0;
        else if (pick < 90)
            u.fuel = 16'hFFFF;
        else
            u.fuel = 16'($urandom_range(1000, 2000));
        return u;
    endfunction

    // Waits until every queued update is accepted and every result has come back,
    // then lets the pipeline settle.
    task automatic wait_drained();
        while (update_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // The configuration write only happens with the block idle, so the model takes
    // the new full_fuel right at the handshake; the residual is left alone.
    task automatic write_full_fuel(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        full_fuel_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input bit long_stall);
        for (int n = 0; n < count; n++)
            update_q.push_back(rand_update());
        if (long_stall) begin
            repeat (100) @(posedge i_clk);
            hold_req = 1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset value of full_fuel.
        push_update(32'd0, 1'b1, 4'h0, 4'h0, 8'h00, 16'hFFFF);        // all-zero command taken
        push_update(32'd100, 1'b0, 4'h0, 4'h0, 8'h00, 16'hFFFF);
        push_update(32'd0, 1'b1, 4'hF, 4'hF, 8'hFF, 16'hFFFF);
        push_update(32'hFFFF_FFFF, 1'b0, 4'h0, 4'h0, 8'h00, 16'd1000); // saturates at zero
        push_update(32'd0, 1'b1, 4'h1, 4'h1, 8'd1, 16'd100);
        push_update(32'd999, 1'b0, 4'h0, 4'h0, 8'h00, 16'd100);       // just short of duration
        push_update(32'd1000, 1'b0, 4'h0, 4'h0, 8'h00, 16'd100);      // duration reached
        push_update(32'd0, 1'b1, 4'h2, 4'h7, 8'd3, 16'h8000);
        push_update(32'd0, 1'b1, 4'h4, 4'h9, 8'd3, 16'h8000);
        push_update(32'd0, 1'b1, 4'h8, 4'hC, 8'd200, 16'h0001);
        push_update(32'd200000, 1'b0, 4'h0, 4'h0, 8'h00, 16'h0000);   // empty tank
        push_update(32'd0, 1'b1, 4'hF, 4'hF, 8'hFF, 16'h0001);
        push_update(32'hFFFF_FFFF, 1'b0, 4'hF, 4'hF, 8'hFF, 16'hFFFF); // widest consumption
        push_update(32'd0, 1'b1, 4'h5, 4'hA, 8'h00, 16'h5555);
        push_update(32'd0, 1'b0, 4'h0, 4'h0, 8'h00, 16'h5555);        // zero duration clears
        push_update(32'hAAAA_AAAA, 1'b1, 4'hA, 4'h5, 8'hAA, 16'hAAAA);
        push_update(32'h5555_5555, 1'b1, 4'h5, 4'hA, 8'h55, 16'h5555);
        push_update(32'd12345, 1'b0, 4'h0, 4'h0, 8'h00, 16'h0000);
        push_update(32'd0, 1'b1, 4'hF, 4'h8, 8'h80, 16'h7FFF);
        push_update(32'd1, 1'b1, 4'h3, 4'h1, 8'h01, 16'hFFFF);
        wait_drained();

        // Random phases across several full_fuel settings, extremes included.
        random_phase(300, 1'b1);
        write_full_fuel(32'd1);
        random_phase(120, 1'b0);
        write_full_fuel(32'd0);       // zero is taken as one; residual reloads to zero
        random_phase(100, 1'b0);
        write_full_fuel(32'hFFFF_FFFF);
        random_phase(150, 1'b0);
        write_full_fuel(32'd1000);
        random_phase(150, 1'b1);
        write_full_fuel($urandom_range(2, 50000));
        random_phase(150, 1'b0);
        write_full_fuel($urandom);
        random_phase(150, 1'b0);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
